[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, held off while reset is asserted.
`define TQ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked check that also holds during reset.
`define TQ_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");

`else

`define TQ_ASSERT(lbl, clk, rst_n, prop)
`define TQ_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

[rtl/tqrt_pkg.sv]
package tqrt_pkg;

    localparam int ParamLimit = 16;
    localparam int PCountW    = $clog2(ParamLimit + 1);
    localparam int TimeWidth  = 32;
    localparam int QDepth     = 4;
    localparam int QPtrW      = $clog2(QDepth);
    localparam int QCountW    = $clog2(QDepth + 1);

    localparam logic [7:0]  ChEsc        = 8'h1b;
    localparam logic [7:0]  PendMax      = 8'hff;
    localparam logic [15:0] TimeoutReset = 16'd500;

    // Response / query classes
    localparam logic [1:0] RESP_NONE = 2'd0;
    localparam logic [1:0] RESP_CPR  = 2'd1;
    localparam logic [1:0] RESP_DSR  = 2'd2;
    localparam logic [1:0] RESP_DA   = 2'd3;

    // Register byte addresses
    localparam logic [2:0] ADDR_TIMEOUT = 3'd0;

    // Operation handed from front to back
    typedef struct packed {
        logic                 fin;    // 1: end of web message, 0: query stamp
        logic [1:0]           rtype;
        logic                 active;
        logic [TimeWidth-1:0] now;
    } t_op;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

[rtl/tqrt_if.sv]
interface tqrt_in_if;
    import tqrt_pkg::*;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic        last_in_message;
    logic        tcp_active;
    logic [31:0] now_ms;

    modport source (output valid, kind, data_byte, last_in_message, tcp_active, now_ms,
                    input ready);
    modport sink   (input valid, kind, data_byte, last_in_message, tcp_active, now_ms,
                    output ready);
endinterface

interface tqrt_out_if;
    logic       valid;
    logic       ready;
    logic       suppress;
    logic [1:0] response_type;

    modport source (output valid, suppress, response_type, input ready);
    modport sink   (input valid, suppress, response_type, output ready);
endinterface

[rtl/tqrt_front.sv]
module tqrt_front
    import tqrt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    tqrt_in_if.sink       i_in,
    input  t_q_stat       i_q_stat,
    output logic          o_push,
    output t_op           o_push_op
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ESC  = 2'd1;
    localparam logic [1:0] ST_CSI  = 2'd2;

    localparam logic [3:0] F_INVALID = 4'b0001;
    localparam logic [3:0] F_PRIVATE = 4'b0010;
    localparam logic [3:0] F_DIGIT   = 4'b0100;
    localparam logic [3:0] F_SEMI    = 4'b1000;

    logic [1:0]         r_pstate, n_pstate;
    logic [PCountW-1:0] r_pcount, n_pcount;
    logic [7:0]         r_pfirst, n_pfirst;
    logic [7:0]         r_psecond, n_psecond;
    logic [1:0]         r_mpos, n_mpos;
    logic [3:0]         r_mflags, n_mflags;

    logic       accept;
    logic [7:0] v;
    logic       stamp_en;
    logic [1:0] stamp_type;
    logic [1:0] msg_type;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign v          = i_in.data_byte;

    function automatic logic params_are(input logic [PCountW-1:0] cnt,
                                        input logic [7:0] first,
                                        input logic [7:0] second,
                                        input logic [7:0] a,
                                        input logic [7:0] b,
                                        input logic [PCountW-1:0] n);
        params_are = (cnt == n) && (first == a) && ((n < PCountW'(2)) || (second == b));
    endfunction

    // Serial-side ESC/CSI parser
    always_comb begin
        n_pstate   = r_pstate;
        n_pcount   = r_pcount;
        n_pfirst   = r_pfirst;
        n_psecond  = r_psecond;
        stamp_en   = 1'b0;
        stamp_type = RESP_NONE;
        unique case (r_pstate)
            ST_IDLE: begin
                if (v == ChEsc) n_pstate = ST_ESC;
            end
            ST_ESC: begin
                if (v == 8'h5b) begin
                    n_pstate = ST_CSI;
                    n_pcount = '0;
                end else begin
                    if (v == 8'h5a && i_in.tcp_active) begin
                        stamp_en   = 1'b1;
                        stamp_type = RESP_DA;
                    end
                    n_pstate = (v == ChEsc) ? ST_ESC : ST_IDLE;
                end
            end
            default: begin
                if (v == ChEsc) begin
                    n_pstate = ST_ESC;
                    n_pcount = '0;
                end else if (v >= 8'h30 && v <= 8'h3f) begin
                    if (r_pcount < PCountW'(ParamLimit)) begin
                        if (r_pcount == '0) n_pfirst = v;
                        else if (r_pcount == PCountW'(1)) n_psecond = v;
                        n_pcount = r_pcount + PCountW'(1);
                    end
                end else if (v >= 8'h20 && v <= 8'h2f) begin
                    // intermediate byte: hold state
                end else begin
                    if (v >= 8'h40 && v <= 8'h7e && i_in.tcp_active) begin
                        if (v == 8'h6e) begin
                            if (params_are(r_pcount, r_pfirst, r_psecond, 8'h36, 8'h00,
                                           PCountW'(1)) ||
                                params_are(r_pcount, r_pfirst, r_psecond, 8'h3f, 8'h36,
                                           PCountW'(2))) begin
                                stamp_en   = 1'b1;
                                stamp_type = RESP_CPR;
                            end else if (params_are(r_pcount, r_pfirst, r_psecond, 8'h35,
                                                    8'h00, PCountW'(1)) ||
                                         params_are(r_pcount, r_pfirst, r_psecond, 8'h3f,
                                                    8'h35, PCountW'(2))) begin
                                stamp_en   = 1'b1;
                                stamp_type = RESP_DSR;
                            end
                        end else if (v == 8'h63) begin
                            stamp_en   = 1'b1;
                            stamp_type = RESP_DA;
                        end
                    end
                    n_pstate = ST_IDLE;
                    n_pcount = '0;
                end
            end
        endcase
    end

    // Web message classifier
    always_comb begin
        n_mpos   = r_mpos;
        n_mflags = r_mflags;
        msg_type = RESP_NONE;
        if (i_in.last_in_message) begin
            if (r_mpos == 2'd3 && !r_mflags[0] && r_mflags[2]) begin
                if (v == 8'h52 && r_mflags[3]) msg_type = RESP_CPR;
                else if (v == 8'h6e) msg_type = RESP_DSR;
                else if (v == 8'h63 && r_mflags[1]) msg_type = RESP_DA;
            end
            n_mpos   = 2'd0;
            n_mflags = 4'd0;
        end else begin
            if (r_mpos == 2'd0) begin
                if (v != ChEsc) n_mflags = r_mflags | F_INVALID;
            end else if (r_mpos == 2'd1) begin
                if (v != 8'h5b) n_mflags = r_mflags | F_INVALID;
            end else if (r_mpos == 2'd2 && (v == 8'h3f || v == 8'h3e)) begin
                n_mflags = r_mflags | F_PRIVATE;
            end else if (v >= 8'h30 && v <= 8'h39) begin
                n_mflags = r_mflags | F_DIGIT;
            end else if (v == 8'h3b) begin
                n_mflags = r_mflags | F_SEMI;
            end else begin
                n_mflags = r_mflags | F_INVALID;
            end
            if (r_mpos != 2'd3) n_mpos = r_mpos + 2'd1;
        end
    end

    // Hand operations to the queue
    assign o_push = accept && (i_in.kind ? i_in.last_in_message : stamp_en);
    always_comb begin
        o_push_op.fin    = i_in.kind;
        o_push_op.rtype  = i_in.kind ? msg_type : stamp_type;
        o_push_op.active = i_in.tcp_active;
        o_push_op.now    = i_in.now_ms;
    end

    // Advance the parser that the item belongs to
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pstate  <= ST_IDLE;
            r_pcount  <= '0;
            r_pfirst  <= '0;
            r_psecond <= '0;
            r_mpos    <= '0;
            r_mflags  <= '0;
        end else if (accept) begin
            if (!i_in.kind) begin
                r_pstate  <= n_pstate;
                r_pcount  <= n_pcount;
                r_pfirst  <= n_pfirst;
                r_psecond <= n_psecond;
            end else begin
                r_mpos   <= n_mpos;
                r_mflags <= n_mflags;
            end
        end
    end

endmodule

[rtl/tqrt_fifo.sv]
module tqrt_fifo
    import tqrt_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_op     i_push_op,
    input  logic    i_pop,
    output t_op     o_head,
    output t_q_stat o_stat
);

    t_op                r_mem [QDepth];
    logic [QPtrW-1:0]   r_wptr, r_rptr;
    logic [QCountW-1:0] r_count;

    assign o_stat.full  = (r_count == QCountW'(QDepth));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_mem[r_rptr];

    // Store pushed operations
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_push_op;
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + QPtrW'(1);
            if (i_pop)  r_rptr <= r_rptr + QPtrW'(1);
            if (i_push && !i_pop)      r_count <= r_count + QCountW'(1);
            else if (i_pop && !i_push) r_count <= r_count - QCountW'(1);
        end
    end

endmodule

[rtl/tqrt_back.sv]
module tqrt_back
    import tqrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [15:0] i_timeout,
    input  t_op         i_head,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    tqrt_out_if.source  o_out
);

    logic [7:0]           r_pend [3];
    logic [TimeWidth-1:0] r_when [3];
    logic [7:0]           n_pend [3];
    logic [TimeWidth-1:0] n_when [3];
    logic                 r_out_valid;
    logic                 r_sup, n_sup;
    logic [1:0]           r_type;

    logic                 out_free;
    logic [1:0]           idx;
    logic [7:0]           sel_pend;
    logic [TimeWidth-1:0] sel_when;
    logic [TimeWidth-1:0] elapsed;
    logic                 in_window;

    assign out_free = !r_out_valid || o_out.ready;
    assign o_pop    = !i_q_stat.empty && (!i_head.fin || out_free);

    // Select the counter the head operation refers to
    assign idx = i_head.rtype - 2'd1;
    always_comb begin
        unique case (i_head.rtype)
            RESP_CPR: begin sel_pend = r_pend[0]; sel_when = r_when[0]; end
            RESP_DSR: begin sel_pend = r_pend[1]; sel_when = r_when[1]; end
            RESP_DA:  begin sel_pend = r_pend[2]; sel_when = r_when[2]; end
            default:  begin sel_pend = '0;        sel_when = '0;        end
        endcase
    end

    assign elapsed   = i_head.now - sel_when;
    assign in_window = (elapsed <= TimeWidth'(i_timeout));

    // Stamp a query or settle a finished message
    always_comb begin
        n_pend = r_pend;
        n_when = r_when;
        n_sup  = 1'b0;
        if (!i_head.fin) begin
            if (i_head.rtype != RESP_NONE) begin
                if (sel_pend != PendMax) n_pend[idx] = sel_pend + 8'd1;
                n_when[idx] = i_head.now;
            end
        end else if (!i_head.active) begin
            n_pend[0] = '0;
            n_pend[1] = '0;
            n_pend[2] = '0;
        end else if (i_head.rtype != RESP_NONE && sel_pend != 8'd0) begin
            if (in_window) begin
                n_pend[idx] = sel_pend - 8'd1;
                n_sup       = 1'b1;
            end else begin
                n_pend[idx] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '{default: '0};
            r_when <= '{default: '0};
        end else if (o_pop) begin
            r_pend <= n_pend;
            r_when <= n_when;
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.fin) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.fin) begin
            r_sup  <= n_sup;
            r_type <= i_head.rtype;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.suppress      = r_sup;
    assign o_out.response_type = r_type;

endmodule

[rtl/terminal_query_response_tracker.sv]
// Channel  Dir  Handshake      Payload
// i_in     in   valid/ready    kind, data_byte, last_in_message, tcp_active, now_ms
// o_out    out  valid/ready    suppress, response_type
// apb      in   psel/penable   paddr, pwdata -> prdata (response_timeout_ms at 0x0)
//
// One item per cycle is accepted while the four-entry operation queue has room.
// The back end retires one operation per cycle unless a finished message waits for
// an untaken result; a result passes the queue write, then the result register.
// Reset is synchronous, active low; pending counts clear, timeout returns to 500.
// A stalled output holds its result and backs up the queue, then i_in.ready.
`include "assert_macros.svh"

module terminal_query_response_tracker
    import tqrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    tqrt_in_if.sink     i_in,
    tqrt_out_if.source  o_out,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    logic [15:0] r_timeout;
    logic        push, pop;
    t_op         push_op, head;
    t_q_stat     q_stat;
    logic        cfg_sel;

    // Configuration register
    assign cfg_sel  = (i_paddr[2] == ADDR_TIMEOUT[2]);
    assign o_pready = 1'b1;
    assign o_prdata = cfg_sel ? {16'd0, r_timeout} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TimeoutReset;
        end else if (i_psel && i_penable && i_pwrite && cfg_sel) begin
            r_timeout <= i_pwdata[15:0];
        end
    end

    tqrt_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_q_stat  (q_stat),
        .o_push    (push),
        .o_push_op (push_op)
    );

    tqrt_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_push_op (push_op),
        .i_pop     (pop),
        .o_head    (head),
        .o_stat    (q_stat)
    );

    tqrt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_timeout (r_timeout),
        .i_head    (head),
        .i_q_stat  (q_stat),
        .o_pop     (pop),
        .o_out     (o_out)
    );

    // Queue is never both full and empty
    `TQ_ASSERT(a_q_consistent, i_clk, i_rst_n, !(q_stat.full && q_stat.empty))
    // No push into a full queue unless it drains in the same cycle
    `TQ_ASSERT(a_no_overflow, i_clk, i_rst_n, (push && q_stat.full) |-> pop)
    // A result appears only after a finished message left the queue
    `TQ_ASSERT(a_result_source, i_clk, i_rst_n, $rose(o_out.valid) |-> $past(pop && head.fin))
    // Never pop an empty queue
    `TQ_ASSERT(a_no_underflow, i_clk, i_rst_n, pop |-> !q_stat.empty)

endmodule

[tb/sv/terminal_query_response_tracker_tb.sv]
module terminal_query_response_tracker_tb;
    import tqrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic KIND_SERIAL = 1'b0;
    localparam logic KIND_WEB    = 1'b1;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_ESC,
        SCAN_CSI
    } t_scan;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic        last;
        logic        active;
        logic [31:0] now;
    } t_stream_byte;

    typedef struct packed {
        logic       suppress;
        logic [1:0] rtype;
    } t_verdict;

    typedef logic [7:0] t_byte_q[$];

    logic        i_clk;
    logic        i_rst_n;
    logic        apb_sel;
    logic        apb_en;
    logic        apb_write;
    logic [2:0]  apb_addr;
    logic [31:0] apb_wdata;
    logic [31:0] apb_rdata;
    logic        apb_ready;

    tqrt_in_if  in_if();
    tqrt_out_if out_if();

    terminal_query_response_tracker u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_if),
        .o_out     (out_if),
        .i_psel    (apb_sel),
        .i_penable (apb_en),
        .i_pwrite  (apb_write),
        .i_paddr   (apb_addr),
        .i_pwdata  (apb_wdata),
        .o_prdata  (apb_rdata),
        .o_pready  (apb_ready)
    );

    // Stimulus and expectation stores
    t_stream_byte bytes_to_send[$];
    t_verdict     verdicts_due[$];
    int unsigned  bytes_queued;
    int unsigned  bytes_accepted;
    int unsigned  mismatches;

    // Handshake bookkeeping
    logic         in_fire;
    logic         out_fire;
    int unsigned  send_hold;
    int unsigned  rcv_hold;
    int unsigned  send_idle_max;
    int unsigned  rcv_idle_max;
    t_stream_byte next_byte;

    // Generator time base
    logic [31:0]  now_clock;
    logic         hold_time;
    string        esc_s;

    // Predicted block state
    logic [15:0]  timeout_ms;
    t_scan        scan_st;
    int unsigned  par_cnt;
    logic [7:0]   par_first;
    logic [7:0]   par_second;
    logic [7:0]   pend_cnt [4];
    logic [31:0]  query_ms [4];
    int unsigned  msg_pos;
    logic         msg_bad;
    logic         msg_priv;
    logic         msg_digit;
    logic         msg_semi;

    // ---------------------------------------------------------------- predictor

    // Count one query of a class, saturating, and stamp its time
    function automatic void note_query(logic [1:0] cls, logic [31:0] now);
        if (pend_cnt[cls] != PendMax) begin
            pend_cnt[cls] = pend_cnt[cls] + 8'd1;
        end
        query_ms[cls] = now;
    endfunction

    function automatic bit params_match(logic [7:0] a, logic [7:0] b, int unsigned n);
        return par_cnt == n && par_first == a && (n < 2 || par_second == b);
    endfunction

    // Advance the ESC/CSI scanner by one serial byte
    function automatic void scan_serial(logic [7:0] v, logic active, logic [31:0] now);
        case (scan_st)
            SCAN_IDLE: begin
                if (v == ChEsc) begin
                    scan_st = SCAN_ESC;
                end
            end
            SCAN_ESC: begin
                if (v == "[") begin
                    scan_st = SCAN_CSI;
                    par_cnt = 0;
                end else begin
                    if (v == "Z" && active) begin
                        note_query(RESP_DA, now);
                    end
                    scan_st = (v == ChEsc) ? SCAN_ESC : SCAN_IDLE;
                end
            end
            default: begin
                if (v == ChEsc) begin
                    scan_st = SCAN_ESC;
                    par_cnt = 0;
                end else if (v >= 8'h30 && v <= 8'h3f) begin
                    // keep the first two parameter characters, drop past the limit
                    if (par_cnt < ParamLimit) begin
                        if (par_cnt == 0) begin
                            par_first = v;
                        end else if (par_cnt == 1) begin
                            par_second = v;
                        end
                        par_cnt++;
                    end
                end else if (!(v >= 8'h20 && v <= 8'h2f)) begin
                    // final byte or junk ends the sequence
                    if (v >= 8'h40 && v <= 8'h7e && active) begin
                        if (v == "n") begin
                            if (params_match("6", 8'h00, 1) || params_match("?", "6", 2)) begin
                                note_query(RESP_CPR, now);
                            end else if (params_match("5", 8'h00, 1) ||
                                         params_match("?", "5", 2)) begin
                                note_query(RESP_DSR, now);
                            end
                        end else if (v == "c") begin
                            note_query(RESP_DA, now);
                        end
                    end
                    scan_st = SCAN_IDLE;
                    par_cnt = 0;
                end
            end
        endcase
    endfunction

    // Fold one non-final web byte into the message flags
    function automatic void scan_reply_byte(logic [7:0] v);
        if (msg_pos == 0) begin
            if (v != ChEsc) msg_bad = 1'b1;
        end else if (msg_pos == 1) begin
            if (v != "[") msg_bad = 1'b1;
        end else if (msg_pos == 2 && (v == "?" || v == ">")) begin
            msg_priv = 1'b1;
        end else if (v >= 8'h30 && v <= 8'h39) begin
            msg_digit = 1'b1;
        end else if (v == ";") begin
            msg_semi = 1'b1;
        end else begin
            msg_bad = 1'b1;
        end
        if (msg_pos < 3) msg_pos++;
    endfunction

    function automatic logic [1:0] class_of_reply(logic [7:0] v);
        if (msg_pos < 3 || msg_bad || !msg_digit) return RESP_NONE;
        if (v == "R" && msg_semi) return RESP_CPR;
        if (v == "n") return RESP_DSR;
        if (v == "c" && msg_priv) return RESP_DA;
        return RESP_NONE;
    endfunction

    // Consume one pending query if still fresh; clear a stale count
    function automatic logic take_pending(logic [1:0] cls, logic [31:0] now);
        logic [31:0] elapsed;
        if (pend_cnt[cls] == 8'd0) return 1'b0;
        elapsed = now - query_ms[cls];
        if (elapsed > {16'd0, timeout_ms}) begin
            pend_cnt[cls] = 8'd0;
            return 1'b0;
        end
        pend_cnt[cls] = pend_cnt[cls] - 8'd1;
        return 1'b1;
    endfunction

    function automatic void track_byte(logic kind, logic [7:0] v, logic last, logic active,
                                       logic [31:0] now);
        t_verdict due;
        if (kind == KIND_SERIAL) begin
            scan_serial(v, active, now);
        end else if (!last) begin
            scan_reply_byte(v);
        end else begin
            due.rtype    = class_of_reply(v);
            due.suppress = 1'b0;
            msg_pos   = 0;
            msg_bad   = 1'b0;
            msg_priv  = 1'b0;
            msg_digit = 1'b0;
            msg_semi  = 1'b0;
            if (!active) begin
                pend_cnt[RESP_CPR] = 8'd0;
                pend_cnt[RESP_DSR] = 8'd0;
                pend_cnt[RESP_DA]  = 8'd0;
            end else if (due.rtype != RESP_NONE) begin
                due.suppress = take_pending(due.rtype, now);
            end
            verdicts_due.push_back(due);
        end
    endfunction

    function automatic void check_verdict(logic sup, logic [1:0] rtype);
        t_verdict want;
        if (verdicts_due.size() == 0) begin
            $display("%0t: unexpected result suppress=%0b response_type=%0d",
                     $time, sup, rtype);
            mismatches++;
            return;
        end
        want = verdicts_due.pop_front();
        if (sup !== want.suppress) begin
            $display("%0t: suppress expected %0b actual %0b", $time, want.suppress, sup);
            mismatches++;
        end
        if (rtype !== want.rtype) begin
            $display("%0t: response_type expected %0d actual %0d", $time, want.rtype, rtype);
            mismatches++;
        end
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void advance_clock();
        int unsigned r;
        if (hold_time) return;
        r = $urandom_range(0, 39);
        if (r < 24) begin
            now_clock += $urandom_range(0, 2);
        end else if (r < 36) begin
            now_clock += $urandom_range(0, 60);
        end else if (r < 39) begin
            now_clock += $urandom_range(0, 1200);
        end else begin
            now_clock = $urandom();
        end
    endfunction

    function automatic void push_byte(logic kind, logic [7:0] data, logic last, logic active);
        t_stream_byte b;
        advance_clock();
        b.kind   = kind;
        b.data   = data;
        b.last   = last;
        b.active = active;
        b.now    = now_clock;
        bytes_to_send.push_back(b);
        bytes_queued++;
    endfunction

    function automatic t_byte_q to_bytes(string s);
        t_byte_q q;
        foreach (s[i]) q.push_back(s[i]);
        return q;
    endfunction

    // Serial bytes; when noisy, flip the link and set stray last flags now and then
    function automatic void push_serial_seq(t_byte_q q, logic active, logic noisy);
        foreach (q[i]) begin
            push_byte(KIND_SERIAL, q[i], noisy && $urandom_range(0, 7) == 0,
                      active ^ (noisy && $urandom_range(0, 29) == 0));
        end
    endfunction

    // Web message bytes, last flag on the final one; when noisy, interleave serial bytes
    function automatic void push_reply_seq(t_byte_q q, logic active, logic noisy);
        foreach (q[i]) begin
            if (noisy && $urandom_range(0, 11) == 0) begin
                push_byte(KIND_SERIAL, $urandom_range(0, 255), 1'b0, active);
            end
            push_byte(KIND_WEB, q[i], i == q.size() - 1,
                      active ^ (noisy && $urandom_range(0, 29) == 0));
        end
    endfunction

    function automatic string query_text();
        string params;
        case ($urandom_range(0, 4))
            0: params = "";
            1: params = "0";
            2: params = "?1;2";
            3: params = ">";
            default: params = $sformatf("%0d", $urandom_range(0, 99));
        endcase
        case ($urandom_range(0, 6))
            0: return {esc_s, "[6n"};
            1: return {esc_s, "[?6n"};
            2: return {esc_s, "[5n"};
            3: return {esc_s, "[?5n"};
            4: return {esc_s, "[", params, "c"};
            5: return {esc_s, "Z"};
            default: return {esc_s, esc_s, "Z"};
        endcase
    endfunction

    function automatic string reply_text();
        string pre;
        case ($urandom_range(0, 2))
            0: begin
                return $sformatf("%s[%0d;%0dR", esc_s, $urandom_range(0, 999),
                                 $urandom_range(0, 999));
            end
            1: begin
                if ($urandom_range(0, 3) == 0) pre = "?";
                else pre = "";
                return $sformatf("%s[%s%0dn", esc_s, pre, $urandom_range(0, 9));
            end
            default: begin
                if ($urandom_range(0, 1) == 0) pre = "?";
                else pre = ">";
                return $sformatf("%s[%s%0d;%0dc", esc_s, pre, $urandom_range(0, 99),
                                 $urandom_range(0, 9));
            end
        endcase
    endfunction

    function automatic void push_random_sequence();
        t_byte_q     q;
        logic        act;
        int unsigned pick;
        int unsigned n;
        hold_time = ($urandom_range(0, 3) == 0);
        act  = ($urandom_range(0, 6) != 0);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            // terminal query, sometimes with an intermediate byte before the final
            q = to_bytes(query_text());
            if ($urandom_range(0, 9) == 0) q.insert(q.size() - 1, $urandom_range(8'h20, 8'h2f));
            push_serial_seq(q, act, 1'b1);
        end else if (pick < 70) begin
            push_reply_seq(to_bytes(reply_text()), act, 1'b1);
        end else if (pick < 80) begin
            // damaged reply: truncate, corrupt a byte, or drop one
            q = to_bytes(reply_text());
            case ($urandom_range(0, 2))
                0: q = q[0:$urandom_range(0, 2)];
                1: q[$urandom_range(0, q.size() - 1)] = $urandom_range(0, 255);
                default: q.delete(q.size() - 2);
            endcase
            push_reply_seq(q, act, 1'b1);
        end else if (pick < 90) begin
            // serial noise with plenty of ESC
            n = $urandom_range(1, 6);
            repeat (n) begin
                if ($urandom_range(0, 2) == 0) q.push_back(ChEsc);
                else q.push_back($urandom_range(0, 255));
            end
            push_serial_seq(q, act, 1'b1);
        end else if (pick < 95) begin
            // parameter list around the limit
            q = to_bytes({esc_s, "["});
            case ($urandom_range(0, 2))
                0: q.push_back("6");
                1: q.push_back("?");
                default: q.push_back("5");
            endcase
            n = $urandom_range(13, 18);
            repeat (n) q.push_back($urandom_range(8'h30, 8'h3f));
            case ($urandom_range(0, 2))
                0: q.push_back("n");
                1: q.push_back("c");
                default: q.push_back($urandom_range(8'h40, 8'h7e));
            endcase
            push_serial_seq(q, act, 1'b1);
        end else begin
            // web noise
            n = $urandom_range(1, 8);
            repeat (n) q.push_back($urandom_range(0, 255));
            push_reply_seq(q, act, 1'b1);
        end
    endfunction

    function automatic void push_directed();
        hold_time = 1'b1;
        now_clock = 32'hffff_ff00;
        // response right at the timeout edge, across the time wrap
        push_serial_seq(to_bytes({esc_s, "[6n"}), 1'b1, 1'b0);
        now_clock += 500;
        push_reply_seq(to_bytes({esc_s, "[1;1R"}), 1'b1, 1'b0);
        // one past the edge: stale count
        push_serial_seq(to_bytes({esc_s, "Z"}), 1'b1, 1'b0);
        now_clock += 501;
        push_reply_seq(to_bytes({esc_s, "[?1c"}), 1'b1, 1'b0);
        // inactive link still classifies
        push_reply_seq(to_bytes({esc_s, "[0n"}), 1'b0, 1'b0);
        // short messages
        push_reply_seq(to_bytes({esc_s, "[n"}), 1'b1, 1'b0);
        push_reply_seq(to_bytes({esc_s, "["}), 1'b1, 1'b0);
        // last flag on a serial byte, one-byte message
        push_byte(KIND_SERIAL, 8'hff, 1'b1, 1'b1);
        push_byte(KIND_WEB, 8'h00, 1'b1, 1'b1);
    endfunction

    // Drive the attribute count into saturation, then answer twice
    function automatic void push_da_flood();
        hold_time = 1'b1;
        repeat (257) begin
            push_byte(KIND_SERIAL, ChEsc, 1'b0, 1'b1);
            push_byte(KIND_SERIAL, "Z", 1'b0, 1'b1);
        end
        repeat (2) push_reply_seq(to_bytes({esc_s, "[?62;1c"}), 1'b1, 1'b0);
    endfunction

    task automatic set_timeout(input logic [15:0] ms);
        @(negedge i_clk);
        apb_sel   = 1'b1;
        apb_en    = 1'b0;
        apb_write = 1'b1;
        apb_addr  = ADDR_TIMEOUT;
        apb_wdata = {16'd0, ms};
        @(negedge i_clk);
        apb_en = 1'b1;
        do @(posedge i_clk); while (!apb_ready);
        @(negedge i_clk);
        apb_sel   = 1'b0;
        apb_en    = 1'b0;
        apb_write = 1'b0;
        timeout_ms = ms;
    endtask

    // Wait until every item is taken and every result is back, then let the pipe empty
    task automatic wait_drained();
        do @(negedge i_clk);
        while (bytes_queued != bytes_accepted || verdicts_due.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- clock and limit

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("terminal_query_response_tracker_tb failed");
        $finish;
    end

    // ---------------------------------------------------------------- driver

    // Present the next item once the current one is taken, after its drawn gap
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            send_hold = 0;
        end else if (!in_if.valid || in_fire) begin
            if (send_hold != 0) begin
                send_hold--;
                in_if.valid <= 1'b0;
            end else if (bytes_to_send.size() != 0) begin
                next_byte = bytes_to_send.pop_front();
                in_if.valid           <= 1'b1;
                in_if.kind            <= next_byte.kind;
                in_if.data_byte       <= next_byte.data;
                in_if.last_in_message <= next_byte.last;
                in_if.tcp_active      <= next_byte.active;
                in_if.now_ms          <= next_byte.now;
                send_hold = $urandom_range(0, send_idle_max);
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Stall the result side for a drawn number of cycles after each result
    always @(negedge i_clk) begin
        if (out_fire) rcv_hold = $urandom_range(0, rcv_idle_max);
        if (rcv_hold != 0) begin
            rcv_hold--;
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge i_clk) begin
        in_fire  <= i_rst_n && in_if.valid && in_if.ready;
        out_fire <= i_rst_n && out_if.valid && out_if.ready;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            bytes_accepted++;
            track_byte(in_if.kind, in_if.data_byte, in_if.last_in_message,
                       in_if.tcp_active, in_if.now_ms);
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            check_verdict(out_if.suppress, out_if.response_type);
        end
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        int unsigned phase;
        logic [15:0] ms;

        i_rst_n               = 1'b0;
        in_if.valid           = 1'b0;
        in_if.kind            = KIND_SERIAL;
        in_if.data_byte       = 8'h00;
        in_if.last_in_message = 1'b0;
        in_if.tcp_active      = 1'b0;
        in_if.now_ms          = 32'd0;
        out_if.ready          = 1'b0;
        apb_sel               = 1'b0;
        apb_en                = 1'b0;
        apb_write             = 1'b0;
        apb_addr              = ADDR_TIMEOUT;
        apb_wdata             = 32'd0;
        in_fire               = 1'b0;
        out_fire              = 1'b0;
        esc_s                 = $sformatf("%c", ChEsc);
        now_clock             = 32'd0;
        hold_time             = 1'b0;
        send_idle_max         = 8;
        rcv_idle_max          = 8;

        // reset values of the tracked state
        timeout_ms = TimeoutReset;
        scan_st    = SCAN_IDLE;
        par_cnt    = 0;
        par_first  = 8'h00;
        par_second = 8'h00;
        msg_pos    = 0;
        msg_bad    = 1'b0;
        msg_priv   = 1'b0;
        msg_digit  = 1'b0;
        msg_semi   = 1'b0;
        foreach (pend_cnt[i]) begin
            pend_cnt[i] = 8'd0;
            query_ms[i] = 32'd0;
        end

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(posedge i_clk);
        push_directed();

        for (phase = 0; phase < 6; phase++) begin
            if (phase != 0) begin
                // hold the sender until the block is idle, then retune
                wait_drained();
                case (phase)
                    1: ms = 16'd0;
                    2: ms = 16'hffff;
                    3: ms = $urandom_range(1, 65534);
                    4: ms = 16'd1;
                    default: ms = $urandom_range(2, 80);
                endcase
                set_timeout(ms);
                @(posedge i_clk);
                case (phase)
                    1: begin send_idle_max = 8; rcv_idle_max = 0; end
                    2: begin send_idle_max = 0; rcv_idle_max = 8; end
                    4: begin send_idle_max = 0; rcv_idle_max = 0; end
                    5: begin send_idle_max = 3; rcv_idle_max = 8; end
                    default: begin send_idle_max = 8; rcv_idle_max = 8; end
                endcase
            end
            if (phase == 2) push_da_flood();
            repeat (14) push_random_sequence();
        end

        wait_drained();
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("terminal_query_response_tracker_tb passed");
        end else begin
            $display("terminal_query_response_tracker_tb failed");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/tqrt_pkg.sv
rtl/tqrt_if.sv
rtl/tqrt_front.sv
rtl/tqrt_fifo.sv
rtl/tqrt_back.sv
rtl/terminal_query_response_tracker.sv
tb/sv/terminal_query_response_tracker_tb.sv
